// ===== src/hashed_timing_wheel_core_assert.svh =====
// Assertion macros for the timing wheel core.
// Used at the end of the top level; expects clk and rst_n in scope.
`ifndef HASHED_TIMING_WHEEL_CORE_ASSERT_SVH
`define HASHED_TIMING_WHEEL_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HTW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timing wheel check failed");

// Next-cycle implication, disabled during reset
`define HTW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timing wheel check failed");

`endif

// ===== src/htw_pkg.sv =====
// Shared types, field widths, command codes and constant helpers
// for the timing wheel core. No dependencies.
package htw_pkg;

    localparam int MODE_W = 2;
    localparam int ID_W   = 6;
    localparam int TO_W   = 32;
    localparam int TL_W   = 16;
    localparam int STG_W  = 5;
    localparam int VAL_W  = 33;

    localparam int SLOTS_DEF  = 256;
    localparam int TIMERS_DEF = 64;

    localparam logic [TL_W-1:0]  TICK_LEN_RST = 16'd50;
    localparam logic [STG_W-1:0] STAGGER_LAST = 5'd19;

    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        logic [TO_W-1:0]   timeout;
    } cmd_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
    } front_status_t;

    typedef struct packed {
        logic idle;
        logic in_div;
        logic div_busy;
        logic push_last;
    } back_status_t;

    // Shift that turns a tick count into revolutions: one plus the
    // trailing zero count of half the slot count.
    function automatic int round_shift(int slots);
        int v;
        int s;
        v = slots >> 1;
        s = 1;
        for (int k = 0; k < 32; k++) begin
            if (s < 32 && v != 0 && (v & 1) == 0) begin
                v = v >> 1;
                s = s + 1;
            end
        end
        return s;
    endfunction

endpackage

// ===== src/htw_ifs.sv =====
// Valid/ready channel interfaces for command words and expiry words.
// Depends on htw_pkg for field widths.
interface htw_in_if import htw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   tmr_id;
    logic [TO_W-1:0]   timeout;

    modport source (output valid, output mode, output tmr_id, output timeout,
                    input ready);
    modport sink (input valid, input mode, input tmr_id, input timeout,
                  output ready);
endinterface

interface htw_out_if import htw_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] expired_id;
    logic            last;

    modport source (output valid, output expired_id, output last, input ready);
    modport sink (input valid, input expired_id, input last, output ready);
endinterface

// ===== src/htw_front.sv =====
// Front end: accepts command words, drops starts and stops of absent
// timers, and queues the rest for the back end. Depends on htw_pkg, htw_ifs.
module htw_front import htw_pkg::*; #(
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    htw_in_if.sink        in_ch,
    output cmd_t          cmd,
    output logic          cmd_valid,
    input  logic          cmd_pop,
    output front_status_t status
);

    localparam logic [1:0] Q_FULL = 2'd2;

    cmd_t       q_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       keep;
    logic       push;
    logic       pop;

    // Classify: ticks always pass, others only for existing timers
    assign keep = (in_ch.mode == MODE_TICK) ||
                  ({1'b0, in_ch.tmr_id} < (ID_W + 1)'(TIMERS));

    assign in_ch.ready = (count_reg != Q_FULL);
    assign push        = in_ch.valid && in_ch.ready && keep;
    assign pop         = cmd_pop && cmd_valid;
    assign cmd_valid   = (count_reg != 2'd0);
    assign cmd         = q_reg[rptr_reg];

    assign status.count = count_reg;
    assign status.full  = (count_reg == Q_FULL);

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wptr_reg] <= '{mode: in_ch.mode, id: in_ch.tmr_id,
                                 timeout: in_ch.timeout};
    end

endmodule

// ===== src/htw_div.sv =====
// Restoring divider, one quotient bit per cycle, for tick count
// conversion. Depends on htw_pkg.
module htw_div import htw_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] dividend,
    input  logic [TL_W-1:0]  divisor,
    output logic             busy,
    output logic             done,
    output logic [VAL_W-1:0] quotient
);

    localparam int CNT_W = $clog2(VAL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VAL_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VAL_W-1:0] quo_reg;
    logic [TL_W-1:0]  rem_reg;
    logic [TL_W-1:0]  dvs_reg;
    logic [TL_W:0]    trial;
    logic             ge;
    logic [TL_W:0]    rem_sub;

    // One trial subtraction per cycle
    assign trial   = {rem_reg, quo_reg[VAL_W-1]};
    assign ge      = (trial >= {1'b0, dvs_reg});
    assign rem_sub = trial - {1'b0, dvs_reg};

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift quotient bits in, keep remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[VAL_W-2:0], ge};
            rem_reg <= ge ? rem_sub[TL_W-1:0] : trial[TL_W-1:0];
        end
    end

endmodule

// ===== src/htw_back.sv =====
// Back end: timer table, wheel hand, tick scan, filing and expiry output.
// Depends on htw_pkg, htw_ifs and htw_div.
module htw_back import htw_pkg::*; #(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [TL_W-1:0] tick_length,
    input  cmd_t            cmd,
    input  logic            cmd_valid,
    output logic            cmd_pop,
    htw_out_if.source       out_ch,
    output back_status_t    status
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TW     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int SH     = round_shift(SLOTS);
    localparam int ENT_W  = SLOT_W + 2 * TO_W;
    localparam logic [SLOT_W-1:0] MASK      = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] HAND_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [TW-1:0]     IDX_LAST  = TW'(TIMERS - 1);
    localparam logic [VAL_W:0]    SLOTS_V   = (VAL_W + 1)'(SLOTS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_EVAL = 3'd3;
    localparam logic [2:0] ST_NEXT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [SLOT_W-1:0] hand_reg;
    logic [STG_W-1:0]  stagger_reg;
    logic [TIMERS-1:0] armed_reg;
    logic [TIMERS-1:0] periodic_reg;
    logic [TW-1:0]     idx_reg;
    logic [TW-1:0]     file_id_reg;
    logic [TO_W-1:0]   file_reload_reg;
    logic              reload_mode_reg;
    logic              pend_v_reg;
    logic [TW-1:0]     pend_id_reg;
    logic              out_valid_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_last_reg;
    logic [ENT_W-1:0]  rd_data_reg;
    logic [ENT_W-1:0]  mem [TIMERS];

    logic [TL_W-1:0]         eff_tick;
    logic [TW-1:0]           cmd_idx;
    logic [STG_W-1:0]        stg_new;
    logic [TL_W+STG_W-1:0]   stg_add;
    logic [VAL_W-1:0]        start_value;
    logic [SLOT_W-1:0]       rd_slot;
    logic [TO_W-1:0]         rd_rounds;
    logic [TO_W-1:0]         rd_reload;
    logic                    hit;
    logic                    expire;
    logic                    can_push;
    logic [VAL_W-1:0]        delta;
    logic                    big;
    logic [SLOT_W:0]         pos;
    logic [SLOT_W-1:0]       file_slot;
    logic [TO_W-1:0]         file_rounds;

    logic                    div_start;
    logic [VAL_W-1:0]        div_dividend;
    logic                    div_busy;
    logic                    div_done;
    logic [VAL_W-1:0]        div_quo;
    logic                    mem_we;
    logic [TW-1:0]           mem_waddr;
    logic [ENT_W-1:0]        mem_wdata;
    logic                    push;
    logic                    push_last;

    htw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_tick),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Start value: timeout plus stagger in whole ticks for periodic starts
    assign eff_tick    = (tick_length == '0) ? TL_W'(1) : tick_length;
    assign cmd_idx     = cmd.id[TW-1:0];
    assign stg_new     = (stagger_reg == STAGGER_LAST) ? '0 : stagger_reg + 1'b1;
    assign stg_add     = eff_tick * stg_new;
    assign start_value = (cmd.mode == MODE_PERIODIC) ?
                         {1'b0, cmd.timeout} + VAL_W'(stg_add) : {1'b0, cmd.timeout};

    // Split the table entry read for the scan
    assign rd_slot   = rd_data_reg[ENT_W-1 -: SLOT_W];
    assign rd_rounds = rd_data_reg[2*TO_W-1 -: TO_W];
    assign rd_reload = rd_data_reg[TO_W-1:0];
    assign hit       = armed_reg[idx_reg] && (rd_slot == hand_reg);
    assign expire    = hit && (rd_rounds == '0);
    assign can_push  = !out_valid_reg || out_ch.ready;

    // File a timer from the divider quotient
    assign delta       = (div_quo == '0) ? VAL_W'(1) : div_quo;
    assign big         = ({1'b0, delta} > SLOTS_V);
    assign pos         = {1'b0, hand_reg} +
                         (big ? {1'b0, delta[SLOT_W-1:0] & MASK} : delta[SLOT_W:0]);
    assign file_slot   = pos[SLOT_W-1:0] & MASK;
    assign file_rounds = big ? TO_W'(delta >> SH) : '0;

    // Sequence commands, the tick scan and the filing
    always_comb
    begin
        state_next   = state_reg;
        cmd_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = start_value;
        mem_we       = 1'b0;
        mem_waddr    = file_id_reg;
        mem_wdata    = {file_slot, file_rounds, file_reload_reg};
        push         = 1'b0;
        push_last    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.mode) inside
                        MODE_TICK:
                            state_next = ST_READ;
                        MODE_STOP:
                            state_next = ST_IDLE;
                        MODE_ONESHOT, MODE_PERIODIC:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    state_next = reload_mode_reg ? ST_NEXT : ST_IDLE;
                end
            end
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (!hit)
                    state_next = ST_NEXT;
                else if (!expire)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg;
                    mem_wdata  = {rd_slot, rd_rounds - 1'b1, rd_reload};
                    state_next = ST_NEXT;
                end
                else if (!pend_v_reg || can_push)
                begin
                    push = pend_v_reg;
                    if (periodic_reg[idx_reg])
                    begin
                        div_start    = 1'b1;
                        div_dividend = {1'b0, rd_reload};
                        state_next   = ST_DIV;
                    end
                    else
                        state_next = ST_NEXT;
                end
            end
            ST_NEXT:
                state_next = (idx_reg == IDX_LAST) ? ST_FIN : ST_READ;
            ST_FIN:
            begin
                if (!pend_v_reg)
                    state_next = ST_IDLE;
                else if (can_push)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hand_reg      <= '0;
            stagger_reg   <= '0;
            armed_reg     <= '0;
            periodic_reg  <= '0;
            idx_reg       <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && cmd_valid)
            begin
                case (cmd.mode)
                    MODE_TICK:
                    begin
                        hand_reg   <= (hand_reg == HAND_LAST) ? '0 : hand_reg + 1'b1;
                        idx_reg    <= '0;
                        pend_v_reg <= 1'b0;
                    end
                    MODE_STOP:
                        armed_reg[cmd_idx] <= 1'b0;
                    MODE_PERIODIC:
                    begin
                        periodic_reg[cmd_idx] <= 1'b1;
                        stagger_reg           <= stg_new;
                    end
                    default:
                        periodic_reg[cmd_idx] <= 1'b0;
                endcase
            end
            if (state_reg == ST_DIV && div_done)
                armed_reg[file_id_reg] <= 1'b1;
            if (state_reg == ST_EVAL && expire && (!pend_v_reg || can_push))
            begin
                armed_reg[idx_reg] <= 1'b0;
                pend_v_reg         <= 1'b1;
            end
            if (state_reg == ST_NEXT && idx_reg != IDX_LAST)
                idx_reg <= idx_reg + 1'b1;
            if (push)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            file_id_reg     <= cmd_idx;
            file_reload_reg <= cmd.timeout;
            reload_mode_reg <= 1'b0;
        end
        if (state_reg == ST_EVAL && expire && (!pend_v_reg || can_push))
        begin
            pend_id_reg     <= idx_reg;
            file_id_reg     <= idx_reg;
            file_reload_reg <= rd_reload;
            reload_mode_reg <= 1'b1;
        end
        if (push)
        begin
            out_id_reg   <= ID_W'(pend_id_reg);
            out_last_reg <= push_last;
        end
    end

    // Timer table: one write port, one registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[idx_reg];
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.expired_id = out_id_reg;
    assign out_ch.last       = out_last_reg;

    assign status.idle      = (state_reg == ST_IDLE);
    assign status.in_div    = (state_reg == ST_DIV);
    assign status.div_busy  = div_busy;
    assign status.push_last = push && push_last;

endmodule

// ===== src/hashed_timing_wheel_core.sv =====
// A stop takes effect when the back end pops it; a start is filed after the pop,
// once the 33-step divider has run. A tick scans each timer through ST_READ,
// ST_EVAL and ST_NEXT, then ST_FIN; each periodic reload runs the divider again,
// and output stalls hold the scan. One command at a time in the back end; a 2-word
// queue and the output register let the input and output sides stall apart.
// Reset clears armed/periodic bits, hand, stagger, tick_length to 50; table not cleared.
module hashed_timing_wheel_core import htw_pkg::*; #(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick_length_we,
    input  logic [TL_W-1:0] tick_length_wdata,
    htw_in_if.sink          in_ch,
    htw_out_if.source       out_ch
);

    logic [TL_W-1:0] tick_length_reg;
    cmd_t            cmd;
    logic            cmd_valid;
    logic            cmd_pop;
    front_status_t   fst;
    back_status_t    bst;

    // Hold the tick length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_length_reg <= TICK_LEN_RST;
        else if (tick_length_we)
            tick_length_reg <= tick_length_wdata;
    end

    htw_front #(.TIMERS(TIMERS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .status    (fst)
    );

    htw_back #(.SLOTS(SLOTS), .TIMERS(TIMERS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_length (tick_length_reg),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .out_ch      (out_ch),
        .status      (bst)
    );

`include "hashed_timing_wheel_core_assert.svh"

    `HTW_ASSERT_IMP(a_q_bound, 1'b1, fst.count <= 2'd2)
    `HTW_ASSERT_IMP(a_full_stalls, fst.full, !in_ch.ready)
    `HTW_ASSERT_IMP(a_div_in_state, bst.div_busy, bst.in_div)
    `HTW_ASSERT_NXT(a_last_ends_tick, bst.push_last, bst.idle)

endmodule

// ===== test/htw_checker.sv =====
// Expiry checker for the timing wheel core: predicts expiry words from the
// accepted command words and compares them in order. Depends on htw_pkg, htw_ifs.
module htw_checker import htw_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick_length_we,
    input  logic [TL_W-1:0] tick_length_wdata,
    htw_in_if               in_ch,
    htw_out_if              out_ch,
    output int              fail_count,
    output int              pending
);
    localparam int SLOTS  = SLOTS_DEF;
    localparam int TIMERS = TIMERS_DEF;
    localparam int SLOT_BITS = 8;

    typedef struct {
        logic [ID_W-1:0] expired_id;
        logic            last;
    } expiry_t;

    expiry_t         expiry_q[$];
    logic [TL_W-1:0] tick_len;
    logic            armed[TIMERS];
    logic            periodic[TIMERS];
    logic [7:0]      slot_of[TIMERS];
    logic [31:0]     rounds[TIMERS];
    logic [31:0]     reload[TIMERS];
    logic [7:0]      hand;
    logic [STG_W-1:0] stagger;

    function automatic logic [63:0] eff_tick();
        return (tick_len == '0) ? 64'd1 : {48'd0, tick_len};
    endfunction

    // File a timer ahead of the hand with its revolution count
    function automatic void file_timer(int id, logic [63:0] value);
        logic [63:0] delta;
        delta = value / eff_tick();
        if (delta == 0)
            delta = 1;
        if (delta > SLOTS) begin
            slot_of[id] = hand + delta[7:0];
            rounds[id]  = 32'(delta >> SLOT_BITS);
        end else begin
            slot_of[id] = 8'(hand + delta);
            rounds[id]  = '0;
        end
        armed[id] = 1'b1;
    endfunction

    // Advance the hand and collect expiries in ascending id order
    function automatic void predict_tick();
        int first;
        expiry_t e;
        first = expiry_q.size();
        hand = hand + 8'd1;
        for (int i = 0; i < TIMERS; i++) begin
            if (armed[i] && slot_of[i] == hand) begin
                if (rounds[i] != 0) begin
                    rounds[i] = rounds[i] - 1;
                end else begin
                    e.expired_id = ID_W'(i);
                    e.last = 1'b0;
                    expiry_q.push_back(e);
                    armed[i] = 1'b0;
                    if (periodic[i])
                        file_timer(i, {32'd0, reload[i]});
                end
            end
        end
        if (expiry_q.size() > first)
            expiry_q[expiry_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            expiry_q.delete();
            tick_len = TICK_LEN_RST;
            for (int i = 0; i < TIMERS; i++) begin
                armed[i] = 1'b0;
                periodic[i] = 1'b0;
            end
            hand = '0;
            stagger = '0;
            fail_count = 0;
            pending = 0;
        end else begin
            if (tick_length_we)
                tick_len = tick_length_wdata;

            // Predict from the accepted command word
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.mode)
                    MODE_TICK: predict_tick();
                    MODE_STOP: armed[in_ch.tmr_id] = 1'b0;
                    MODE_ONESHOT:
                    begin
                        periodic[in_ch.tmr_id] = 1'b0;
                        reload[in_ch.tmr_id] = in_ch.timeout;
                        file_timer(in_ch.tmr_id, {32'd0, in_ch.timeout});
                    end
                    default:
                    begin
                        periodic[in_ch.tmr_id] = 1'b1;
                        reload[in_ch.tmr_id] = in_ch.timeout;
                        stagger = (stagger == STAGGER_LAST) ? '0 : stagger + 1'b1;
                        file_timer(in_ch.tmr_id,
                                   {32'd0, in_ch.timeout} + eff_tick() * stagger);
                    end
                endcase
            end

            // Compare the accepted expiry word with the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                if (expiry_q.size() == 0) begin
                    $error("unexpected expiry word: expired_id %0d, last %0d",
                           out_ch.expired_id, out_ch.last);
                    fail_count++;
                end else begin
                    if (out_ch.expired_id !== expiry_q[0].expired_id) begin
                        $error("expired_id mismatch: expected %0d, actual %0d",
                               expiry_q[0].expired_id, out_ch.expired_id);
                        fail_count++;
                    end
                    if (out_ch.last !== expiry_q[0].last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               expiry_q[0].last, out_ch.last);
                        fail_count++;
                    end
                    void'(expiry_q.pop_front());
                end
            end
            pending = expiry_q.size();
        end
    end
endmodule

// ===== test/testbench.sv =====
// Top of the timing wheel testbench: clock, reset, command and config stimulus,
// expiry-side flow control and verdict. Depends on htw_pkg, htw_ifs, htw_checker.
module testbench;
    import htw_pkg::*;

    localparam int DRAIN_CYCLES = 3000;
    localparam int HOLD_CYCLES  = 400;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            tick_length_we = 1'b0;
    logic [TL_W-1:0] tick_length_wdata = '0;
    logic [TL_W-1:0] cur_tick_len = TICK_LEN_RST;
    logic            hold_req = 1'b0;
    int              fail_count;
    int              pending;

    htw_in_if  in_ch();
    htw_out_if out_ch();

    hashed_timing_wheel_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .tick_length_we   (tick_length_we),
        .tick_length_wdata(tick_length_wdata),
        .in_ch            (in_ch),
        .out_ch           (out_ch)
    );

    htw_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .tick_length_we   (tick_length_we),
        .tick_length_wdata(tick_length_wdata),
        .in_ch            (in_ch),
        .out_ch           (out_ch),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_STOP;
        in_ch.tmr_id = '0;
        in_ch.timeout = '0;
        out_ch.ready = 1'b0;
    end

    // Send one command word after a random gap, hold until accepted
    task automatic send_cmd(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                            logic [TO_W-1:0] to);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.tmr_id <= id;
        in_ch.timeout <= to;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Wait out every expected expiry and the block's own work
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_length(logic [TL_W-1:0] v);
        drain();
        tick_length_we <= 1'b1;
        tick_length_wdata <= v;
        cur_tick_len = v;
        @(posedge clk);
        tick_length_we <= 1'b0;
    endtask

    // Random command: mostly starts with short delays and ticks
    task automatic send_random();
        int pick;
        logic [31:0] tl;
        logic [31:0] to;
        tl = (cur_tick_len == 0) ? 32'd1 : {16'd0, cur_tick_len};
        pick = $urandom_range(0, 99);
        if (pick < 15)
            to = $urandom;
        else if (pick < 30)
            to = $urandom_range(tl * 200, tl * 600);
        else
            to = $urandom_range(0, tl * 8);
        pick = $urandom_range(0, 99);
        if (pick < 42)
            send_cmd(MODE_TICK, ID_W'($urandom), to);
        else if (pick < 62)
            send_cmd(MODE_ONESHOT, ID_W'($urandom), to);
        else if (pick < 85)
            send_cmd(MODE_PERIODIC, ID_W'($urandom), to);
        else
            send_cmd(MODE_STOP, ID_W'($urandom), to);
    endtask

    // Expiry side: random ready gaps, and a long hold-off on request
    initial
    begin : receiver
        int gap;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero timeout, multiple expiries in one tick, restart
        send_cmd(MODE_ONESHOT, 6'd0, 32'd0);
        send_cmd(MODE_TICK, 6'd0, 32'd0);
        send_cmd(MODE_ONESHOT, 6'd10, 32'd50);
        send_cmd(MODE_ONESHOT, 6'd3, 32'd50);
        send_cmd(MODE_PERIODIC, 6'd7, 32'd0);
        send_cmd(MODE_ONESHOT, 6'd5, 32'd50);
        send_cmd(MODE_ONESHOT, 6'd5, 32'd100);
        send_cmd(MODE_TICK, 6'd63, 32'hFFFF_FFFF);
        send_cmd(MODE_TICK, 6'd0, 32'd0);
        // Directed: huge timeout, stop armed and idle timers
        send_cmd(MODE_ONESHOT, 6'd1, 32'hFFFF_FFFF);
        send_cmd(MODE_STOP, 6'd1, 32'd0);
        send_cmd(MODE_STOP, 6'd2, 32'hFFFF_FFFF);
        // Directed: reload that lands in the current slot, exact multiple of slots
        send_cmd(MODE_PERIODIC, 6'd63, 32'd12800);
        send_cmd(MODE_ONESHOT, 6'd62, 32'd25600);
        send_cmd(MODE_PERIODIC, 6'd20, 32'd100);
        send_cmd(MODE_TICK, 6'd0, 32'd0);
        send_cmd(MODE_TICK, 6'd0, 32'd0);
        send_cmd(MODE_TICK, 6'd0, 32'd0);
        send_cmd(MODE_STOP, 6'd63, 32'd0);
        send_cmd(MODE_STOP, 6'd20, 32'd0);

        // Shortest tick length, with a long receiver hold-off
        write_tick_length(16'd1);
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_cmd(MODE_PERIODIC, ID_W'(i * 8 + 1), 32'd1);
        for (int i = 0; i < 6; i++)
            send_cmd(MODE_TICK, 6'd0, 32'd0);
        for (int i = 0; i < 20; i++)
            send_random();

        // Longest tick length, with a pause until everything has come
        write_tick_length(16'hFFFF);
        for (int i = 0; i < 18; i++)
            send_random();
        drain();
        for (int i = 0; i < 17; i++)
            send_random();

        // Zero tick length behaves as one
        write_tick_length(16'd0);
        for (int i = 0; i < 20; i++)
            send_random();

        // Random tick length
        write_tick_length(TL_W'($urandom_range(2, 400)));
        for (int i = 0; i < 20; i++)
            send_random();

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/htw_pkg.sv
src/htw_ifs.sv
src/htw_front.sv
src/htw_div.sv
src/htw_back.sv
src/hashed_timing_wheel_core.sv
test/htw_checker.sv
test/testbench.sv
